// ===== rtl/core/opat_pkg.sv =====
// Package with shared constants, codes and types of the alarm table.
package opat_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int TW = 48;
    localparam int HW = 16;
    localparam int CW = 5;
    localparam int MAX_RESULTS = 32;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ONCE     = 2'd1;
    localparam logic [1:0] CMD_PERIODIC = 2'd2;
    localparam logic [1:0] CMD_UNADVISE = 2'd3;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_FIRED    = 3'd3;
    localparam logic [2:0] ST_RELEASE  = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;

    typedef struct packed {
        logic          start;
        logic [TW-1:0] dividend;
        logic [TW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [TW-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/opat_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module opat_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  opat_pkg::div_req_t req,
    output opat_pkg::div_rsp_t rsp
);
    localparam int TW = opat_pkg::TW;

    logic [TW-1:0]         quo_reg, quo_next;
    logic [TW-1:0]         rem_reg, rem_next;
    logic [TW-1:0]         dvs_reg, dvs_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [TW:0]           trial;
    logic [TW:0]           diff;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[TW-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'(TW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[TW]) begin
                rem_next = diff[TW-1:0];
                quo_next = {quo_reg[TW-2:0], 1'b1};
            end else begin
                rem_next = trial[TW-1:0];
                quo_next = {quo_reg[TW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> !busy_reg) else $error("divider done while busy");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("divider restarted while busy");
    a_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == 6'd0 || $past(req.start) == 1'b0)
        else $error("divider count inconsistent");
`endif
endmodule

// ===== rtl/core/oneshot_periodic_alarm_table_top.sv =====
// Top level of the alarm table: sequencer, slot memories and result register.
// Each transaction is handled alone, and s_tready stays low until its last result has been
// taken. An unadvise answers straight from S_FIND without a scan. An advise scans for a free
// slot at one slot per cycle and answers full when none is left. A tick visits each one-shot
// slot through S_ORD and S_OCHK, then each periodic slot through S_PRD, S_PDIV and S_PCHK;
// for a slot that has started, S_PDIV waits on the serial divider that computes the elapsed
// periods. Each tick result is held until the next one is known, and the scan pauses while
// an earlier result waits on m_tready. Valid bits clear at reset; there is no clearing pass.
module oneshot_periodic_alarm_table_top #(
    parameter int SLOTS = opat_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], time_value[49:2], time_span[97:50], handle_tag[113:98],
    // cookie[118:114], zero fill to 120
    input  logic [119:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], slot_cookie[7:3], fired_handle[23:8], release_count[39:24]
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    localparam int TW = opat_pkg::TW;
    localparam int HW = opat_pkg::HW;
    localparam int CW = opat_pkg::CW;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [TW-1:0] MAX48 = {TW{1'b1}};

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FIND  = 8'b00000010,
        S_ORD   = 8'b00000100,
        S_OCHK  = 8'b00001000,
        S_PRD   = 8'b00010000,
        S_PDIV  = 8'b00100000,
        S_PCHK  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]    cmd_reg;
    logic [TW-1:0] tv_reg, ts_reg;
    logic [HW-1:0] hd_reg;
    logic [CW-1:0] ck_reg;
    logic [SW:0]   idx_reg, idx_next;
    logic          first_reg;
    logic [5:0]    nres_reg;
    logic          pend_reg;
    logic [39:0]   hold_reg;

    logic [SLOTS-1:0] once_valid_reg, period_valid_reg;
    logic [TW-1:0] once_due   [SLOTS];
    logic [HW-1:0] once_hd    [SLOTS];
    logic [TW-1:0] per_start  [SLOTS];
    logic [TW-1:0] per_len    [SLOTS];
    logic [TW-1:0] per_cnt    [SLOTS];
    logic [HW-1:0] per_hd     [SLOTS];

    logic [TW-1:0] rd_a_reg, rd_b_reg, rd_c_reg;
    logic [HW-1:0] rd_h_reg;

    logic          m_valid_reg;
    logic [39:0]   m_data_reg;
    logic          m_last_reg;

    opat_pkg::div_req_t dreq;
    opat_pkg::div_rsp_t drsp;

    opat_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic [SW-1:0] idx;
    logic [TW:0]   sum;
    logic [TW:0]   cnt1;
    logic [TW-1:0] cnt_sat, dif;
    logic          full_scan;
    logic          per_due;

    assign idx       = idx_reg[SW-1:0];
    assign sum       = {1'b0, tv_reg} + {1'b0, ts_reg};
    assign cnt1      = {1'b0, drsp.quotient} + {{TW{1'b0}}, 1'b1};
    assign cnt_sat   = cnt1[TW] ? MAX48 : cnt1[TW-1:0];
    assign dif       = cnt_sat - rd_c_reg;
    assign full_scan = idx_reg == (SW+1)'(SLOTS);
    assign per_due   = nres_reg != 6'(opat_pkg::MAX_RESULTS) && period_valid_reg[idx]
                       && tv_reg >= rd_a_reg;

    assign dreq.start    = state_reg == S_PDIV && first_reg && per_due;
    assign dreq.dividend = tv_reg - rd_a_reg;
    assign dreq.divisor  = rd_b_reg;

    assign s_tready = state_reg == S_IDLE && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    function automatic logic [39:0] pack(logic [2:0] st, logic [CW-1:0] ck,
                                         logic [HW-1:0] h, logic [HW-1:0] rc);
        return {rc, h, ck, st};
    endfunction

    always_ff @(posedge aclk) begin
        rd_a_reg <= (state_reg == S_ORD) ? once_due[idx] : per_start[idx];
        rd_b_reg <= per_len[idx];
        rd_c_reg <= per_cnt[idx];
        rd_h_reg <= (state_reg == S_ORD) ? once_hd[idx] : per_hd[idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            once_valid_reg   <= '0;
            period_valid_reg <= '0;
            m_valid_reg      <= 1'b0;
            m_last_reg       <= 1'b0;
            idx_reg          <= '0;
            first_reg        <= 1'b0;
            nres_reg         <= '0;
            pend_reg         <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg   <= s_tdata[1:0];
                        tv_reg    <= s_tdata[49:2];
                        ts_reg    <= s_tdata[97:50];
                        hd_reg    <= s_tdata[113:98];
                        ck_reg    <= s_tdata[118:114];
                        idx_reg   <= '0;
                        nres_reg  <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= (s_tdata[1:0] == opat_pkg::CMD_TICK) ? S_ORD : S_FIND;
                    end
                end
                S_FIND: begin
                    if (cmd_reg == opat_pkg::CMD_UNADVISE) begin
                        if ({1'b0, ck_reg} < (CW+1)'(SLOTS)) begin
                            once_valid_reg[ck_reg[SW-1:0]] <= 1'b0;
                        end else if ({1'b0, ck_reg} - (CW+1)'(SLOTS) < (CW+1)'(SLOTS)) begin
                            period_valid_reg[SW'(ck_reg - CW'(SLOTS))] <= 1'b0;
                        end
                        m_data_reg <= pack(opat_pkg::ST_REMOVED, ck_reg, '0, '0);
                        m_last_reg <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (cmd_reg == opat_pkg::CMD_PERIODIC && ts_reg == '0) begin
                        m_data_reg <= pack(opat_pkg::ST_ZERO, '0, '0, '0);
                        m_last_reg <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (full_scan) begin
                        m_data_reg <= pack(opat_pkg::ST_FULL, '0, '0, '0);
                        m_last_reg <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (cmd_reg == opat_pkg::CMD_ONCE && !once_valid_reg[idx]) begin
                        once_valid_reg[idx] <= 1'b1;
                        once_due[idx] <= sum[TW] ? MAX48 : sum[TW-1:0];
                        once_hd[idx]  <= hd_reg;
                        m_data_reg <= pack(opat_pkg::ST_ACCEPTED, CW'(idx_reg), '0, '0);
                        m_last_reg <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (cmd_reg == opat_pkg::CMD_PERIODIC && !period_valid_reg[idx]) begin
                        period_valid_reg[idx] <= 1'b1;
                        per_start[idx] <= tv_reg;
                        per_len[idx]   <= ts_reg;
                        per_cnt[idx]   <= '0;
                        per_hd[idx]    <= hd_reg;
                        m_data_reg <= pack(opat_pkg::ST_ACCEPTED,
                                           CW'(idx_reg + (SW+1)'(SLOTS)), '0, '0);
                        m_last_reg <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_ORD: begin
                    if (!pend_reg || !m_valid_reg) begin
                        state_reg <= S_OCHK;
                    end
                end
                S_OCHK: begin
                    if (nres_reg != 6'(opat_pkg::MAX_RESULTS) && once_valid_reg[idx]
                        && tv_reg > rd_a_reg) begin
                        once_valid_reg[idx] <= 1'b0;
                        if (pend_reg) begin
                            m_data_reg  <= hold_reg;
                            m_last_reg  <= 1'b0;
                            m_valid_reg <= 1'b1;
                        end
                        hold_reg <= pack(opat_pkg::ST_FIRED, CW'(idx_reg), rd_h_reg, '0);
                        pend_reg <= 1'b1;
                        nres_reg <= nres_reg + 6'd1;
                    end
                    if (idx_reg == (SW+1)'(SLOTS - 1)) begin
                        idx_reg <= '0;
                        state_reg <= S_PRD;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_ORD;
                    end
                end
                S_PRD: begin
                    if (!pend_reg || !m_valid_reg) begin
                        first_reg <= 1'b1;
                        state_reg <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    first_reg <= 1'b0;
                    if (!per_due || drsp.done) begin
                        state_reg <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    if (per_due && cnt_sat > rd_c_reg) begin
                        per_cnt[idx] <= cnt_sat;
                        if (pend_reg) begin
                            m_data_reg  <= hold_reg;
                            m_last_reg  <= 1'b0;
                            m_valid_reg <= 1'b1;
                        end
                        hold_reg <= pack(opat_pkg::ST_RELEASE,
                                         CW'(idx_reg + (SW+1)'(SLOTS)), rd_h_reg,
                                         (dif > TW'(16'hFFFF)) ? 16'hFFFF : dif[HW-1:0]);
                        pend_reg <= 1'b1;
                        nres_reg <= nres_reg + 6'd1;
                    end
                    if (idx_reg == (SW+1)'(SLOTS - 1)) begin
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_PRD;
                    end
                end
                S_OUT: begin
                    // The held result goes out as the last one once the output is free.
                    if (!m_valid_reg) begin
                        if (pend_reg) begin
                            m_data_reg  <= hold_reg;
                            m_last_reg  <= 1'b1;
                            m_valid_reg <= 1'b1;
                            pend_reg    <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        nres_reg <= 6'(opat_pkg::MAX_RESULTS)) else $error("too many results");
    a_last_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid || s_tready == 1'b0)
        else $error("result after last");
`endif
endmodule
